>>> hdl/thtp_pkg.sv
// Package for the twelve-hour time text parser: parse phases, character codes,
// limits and the word structures passed between stages. No dependencies.
package thtp_pkg;

  typedef enum logic [2:0] {
    PH_HOUR  = 3'd0,
    PH_MIN1  = 3'd1,
    PH_MIN2  = 3'd2,
    PH_SPACE = 3'd3,
    PH_MERID = 3'd4,
    PH_TRAIL = 3'd5
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UP_A  = 8'd65;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_CASE  = 8'd32;
  localparam logic [7:0] CH_A     = 8'd97;
  localparam logic [7:0] CH_P     = 8'd112;
  localparam logic [7:0] CH_M     = 8'd109;

  localparam logic [3:0]  HOUR_SAT     = 4'd13;
  localparam logic [3:0]  HOUR_MAX     = 4'd12;
  localparam logic [1:0]  HDIG_SAT     = 2'd3;
  localparam logic [6:0]  MIN_LIMIT    = 7'd60;
  localparam logic [10:0] MIN_HALF_DAY = 11'd720;

  // Input word held by the input stage.
  typedef struct packed {
    logic       last_char;
    logic [7:0] char_code;
  } in_word_t;

  // Result word for the output stage.
  typedef struct packed {
    logic [10:0] minute_of_day;
    logic        time_valid;
  } res_word_t;

endpackage

>>> hdl/thtp_in_stage.sv
// Input register stage of the time text parser.
// Depends on thtp_pkg for the input word structure.
module thtp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  thtp_pkg::in_word_t in_word,
  input  logic               take,      // parser consumes the held word
  output logic               hold_valid,
  output thtp_pkg::in_word_t hold_word
);

  logic               valid_r, valid_nxt;
  thtp_pkg::in_word_t word_r;

  // Accept whenever empty or the held word leaves this cycle.
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      word_r <= in_word;
    end
  end

  assign hold_valid = valid_r;
  assign hold_word  = word_r;

endmodule

>>> hdl/thtp_parser.sv
// Parse state and per-character update of the time text parser, plus the
// result computed on the last character. Depends on thtp_pkg.
module thtp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  thtp_pkg::in_word_t  word,
  output thtp_pkg::res_word_t res
);

  thtp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] hour_r, hour_nxt;
  logic [1:0] hdig_r, hdig_nxt;
  logic [6:0] min_r, min_nxt;
  logic       pm_r, pm_nxt;
  logic       err_r, err_nxt;

  logic [7:0] c;
  logic       is_dig;
  logic [7:0] hour_acc;
  logic [6:0] min_acc;
  logic [3:0] hour_mod;
  logic [9:0] hour_min;
  logic       ok;

  // Fold upper case to lower case.
  always_comb begin
    c = word.char_code;
    if (word.char_code >= thtp_pkg::CH_UP_A && word.char_code <= thtp_pkg::CH_UP_Z) begin
      c = word.char_code + thtp_pkg::CH_CASE;
    end
  end

  // Minutes wrap at 7 bits: keep only the low bits of 8*m and 2*m.
  assign is_dig   = (c >= thtp_pkg::CH_ZERO) && (c <= thtp_pkg::CH_NINE);
  assign hour_acc = {1'b0, hour_r, 3'b000} + {3'b000, hour_r, 1'b0} + {4'b0000, c[3:0]};
  assign min_acc  = {min_r[3:0], 3'b000} + {min_r[5:0], 1'b0} + {3'b000, c[3:0]};

  // Next parse state for one character.
  always_comb begin
    phase_nxt = phase_r;
    hour_nxt  = hour_r;
    hdig_nxt  = hdig_r;
    min_nxt   = min_r;
    pm_nxt    = pm_r;
    err_nxt   = err_r;
    if (!err_r) begin
      case (phase_r)
        thtp_pkg::PH_HOUR: begin
          if (is_dig) begin
            hour_nxt = (hour_acc > {4'b0000, thtp_pkg::HOUR_SAT}) ? thtp_pkg::HOUR_SAT
                                                                  : hour_acc[3:0];
            if (hdig_r != thtp_pkg::HDIG_SAT) begin
              hdig_nxt = hdig_r + 2'd1;
            end
          end else if (hdig_r == 2'd0) begin
            err_nxt = 1'b1;
          end else if (c == thtp_pkg::CH_COLON) begin
            if (hdig_r == thtp_pkg::HDIG_SAT) begin
              err_nxt = 1'b1;
            end else begin
              phase_nxt = thtp_pkg::PH_MIN1;
            end
          end else if (c == thtp_pkg::CH_SPACE) begin
            phase_nxt = thtp_pkg::PH_SPACE;
          end else if (c == thtp_pkg::CH_A || c == thtp_pkg::CH_P) begin
            pm_nxt    = (c == thtp_pkg::CH_P);
            phase_nxt = thtp_pkg::PH_MERID;
          end else begin
            err_nxt = 1'b1;
          end
        end
        thtp_pkg::PH_MIN1, thtp_pkg::PH_MIN2: begin
          if (is_dig) begin
            min_nxt = min_acc;
            if (phase_r == thtp_pkg::PH_MIN1) begin
              phase_nxt = thtp_pkg::PH_MIN2;
            end else begin
              err_nxt   = (min_acc >= thtp_pkg::MIN_LIMIT);
              phase_nxt = thtp_pkg::PH_SPACE;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
        thtp_pkg::PH_SPACE: begin
          if (c == thtp_pkg::CH_A || c == thtp_pkg::CH_P) begin
            pm_nxt    = (c == thtp_pkg::CH_P);
            phase_nxt = thtp_pkg::PH_MERID;
          end else if (c != thtp_pkg::CH_SPACE) begin
            err_nxt = 1'b1;
          end
        end
        thtp_pkg::PH_MERID: begin
          if (c == thtp_pkg::CH_M) begin
            phase_nxt = thtp_pkg::PH_TRAIL;
          end else begin
            err_nxt = 1'b1;
          end
        end
        thtp_pkg::PH_TRAIL: begin
          if (c != thtp_pkg::CH_SPACE) begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  // Result from the updated state; twelve o'clock folds to zero.
  assign ok       = !err_nxt && (phase_nxt == thtp_pkg::PH_TRAIL) &&
                    (hour_nxt <= thtp_pkg::HOUR_MAX);
  assign hour_mod = (hour_nxt == thtp_pkg::HOUR_MAX) ? 4'd0 : hour_nxt;
  assign hour_min = {hour_mod, 6'b000000} - {4'b0000, hour_mod, 2'b00};

  always_comb begin
    res.time_valid    = ok;
    res.minute_of_day = 11'd0;
    if (ok) begin
      res.minute_of_day = {1'b0, hour_min} + {4'b0000, min_nxt} +
                          (pm_nxt ? thtp_pkg::MIN_HALF_DAY : 11'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= thtp_pkg::PH_HOUR;
      hour_r  <= 4'd0;
      hdig_r  <= 2'd0;
      min_r   <= 7'd0;
      pm_r    <= 1'b0;
      err_r   <= 1'b0;
    end else if (take) begin
      if (word.last_char) begin
        phase_r <= thtp_pkg::PH_HOUR;
        hour_r  <= 4'd0;
        hdig_r  <= 2'd0;
        min_r   <= 7'd0;
        pm_r    <= 1'b0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        hour_r  <= hour_nxt;
        hdig_r  <= hdig_nxt;
        min_r   <= min_nxt;
        pm_r    <= pm_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && word.last_char |=> phase_r == thtp_pkg::PH_HOUR && !err_r && hour_r == 4'd0)
    else $error("parse state not cleared after last character");

  a_hour_sat: assert property (@(posedge clk) disable iff (!rst_n)
    hour_r <= thtp_pkg::HOUR_SAT)
    else $error("hour accumulator above saturation");

  a_minute_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == thtp_pkg::PH_SPACE || phase_r == thtp_pkg::PH_MERID ||
     phase_r == thtp_pkg::PH_TRAIL) && !err_r |-> min_r < thtp_pkg::MIN_LIMIT)
    else $error("minute value out of range past minutes");

endmodule

>>> hdl/thtp_out_stage.sv
// Output register stage of the time text parser.
// Depends on thtp_pkg for the result word structure.
module thtp_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  thtp_pkg::res_word_t res,
  output logic                space,     // can take a result this cycle
  output logic                out_tvalid,
  input  logic                out_tready,
  output thtp_pkg::res_word_t out_res
);

  logic                valid_r, valid_nxt;
  thtp_pkg::res_word_t res_r;

  assign space = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (space) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

>>> hdl/twelve_hour_time_text_parser_top.sv
// Twelve-hour time text parser. Feed a time string one byte per word on the
// input stream (in_tdata = character, in_tlast on the final character); case
// is ignored and the accepted form is digits, optionally ':' and two minute
// digits, optional spaces, "am" or "pm", optional trailing spaces. Each
// string yields exactly one result word, emitted for its last character:
// bit 0 of out_tdata flags a valid time and bits 11:1 carry the minute of the
// day (0 when rejected). Throughput is one character per clock, save for the
// stall below; a character passes an input register, then combinational parse
// logic into a result register, which loads the result word when the last
// character leaves the input register. Only a full, unread result register
// stalls the input, and only for a last character. Depends on thtp_pkg,
// thtp_in_stage, thtp_parser, thtp_out_stage.
module twelve_hour_time_text_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  input  logic        in_tlast,    // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // [0] time_valid, [11:1] minute_of_day, rest zero
);

  thtp_pkg::in_word_t  in_word;
  thtp_pkg::in_word_t  hold_word;
  thtp_pkg::res_word_t res;
  thtp_pkg::res_word_t out_res;
  logic                hold_valid;
  logic                take;
  logic                space;

  assign in_word.char_code = in_tdata;
  assign in_word.last_char = in_tlast;

  // Advance the held character unless it is a last character facing a full
  // result register.
  assign take = hold_valid && (!hold_word.last_char || space);

  thtp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_word    (in_word),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_word  (hold_word)
  );

  thtp_parser u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .word  (hold_word),
    .res   (res)
  );

  // Load a result only for the last character of a string.
  thtp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && hold_word.last_char),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {4'b0000, out_res.minute_of_day, out_res.time_valid};

  a_zero_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[11:1] == 11'd0)
    else $error("rejected word carries nonzero minutes");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:1] < 11'd1440)
    else $error("minute of day out of range");

  a_stall_last: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid && !hold_word.last_char |-> in_tready)
    else $error("input stalled behind a non-last character");

endmodule
